/* design/card_id_slot_table_macros.svh */
// Assertion macros shared by the card ID slot table RTL.
`ifndef CARD_ID_SLOT_TABLE_MACROS_SVH
`define CARD_ID_SLOT_TABLE_MACROS_SVH

// Checked only while out of reset.
`define CIST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define CIST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cist_pkg.sv */
// Shared types and field widths for the card ID slot table.
package cist_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned IdW   = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned SlotW = 6;
  localparam int unsigned CntW  = 7;

  typedef enum logic [OpW-1:0] {
    OP_ADD       = 3'd0,
    OP_DEL_ID    = 3'd1,
    OP_DEL_ORD   = 3'd2,
    OP_FIND_ID   = 3'd3,
    OP_FIND_NEXT = 3'd4,
    OP_CLEAR     = 3'd5
  } cist_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } cist_state_e;

endpackage

/* design/cist_if.sv */
// Request and response channel interfaces of the card ID slot table.
interface cist_req_if;
  logic                      valid;
  logic                      ready;
  logic [cist_pkg::OpW-1:0]  req_type;
  logic [cist_pkg::IdW-1:0]  card_id;
  logic [cist_pkg::PosW-1:0] position;

  modport source (output valid, req_type, card_id, position, input ready);
  modport sink   (input valid, req_type, card_id, position, output ready);
endinterface

interface cist_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [cist_pkg::SlotW-1:0] slot;
  logic [cist_pkg::CntW-1:0]  entry_count;

  modport source (output valid, status, slot, entry_count, input ready);
  modport sink   (input valid, status, slot, entry_count, output ready);
endinterface

/* design/cist_id_ram.sv */
// Card ID store: one write port, one read port with registered read data.
module cist_id_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  logic [cist_pkg::IdW-1:0] wr_data_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  output logic [cist_pkg::IdW-1:0] rd_data_o
);
  import cist_pkg::*;

  logic [IdW-1:0] mem [Depth];
  logic [IdW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/card_id_slot_table.sv */
// Card ID slot table: sequencer, valid bits, entry count and response register.
// A scan runs from its start slot until a slot matches or the last slot is tested;
// clear and rejected requests skip the scan and go straight to the response state.
// The scan reads the ID memory one slot per cycle on its single read port.
// A new request is taken from the cycle after the response is registered, one request at a
// time; a response still waiting holds the next response back until it is taken.
// Reset clears valid bits, count and control at once; the ID memory is left as is.
`include "card_id_slot_table_macros.svh"

module card_id_slot_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cist_req_if.sink   req_i,
  cist_rsp_if.source rsp_o
);
  import cist_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW = (CW > PosW) ? CW : PosW;
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(TABLE_DEPTH);

  cist_state_e state_q, state_d;

  logic [OpW-1:0]         op_q, op_d;
  logic [IdW-1:0]         id_q, id_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [IW-1:0]          scan_idx_q, scan_idx_d;
  logic                   issue_end_q, issue_end_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [IW-1:0]          chk_idx_q, chk_idx_d;
  logic [CW-1:0]          seen_q, seen_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   res_fail_q, res_fail_d;
  logic [IW-1:0]          res_slot_q, res_slot_d;
  logic                   rsp_valid_q, rsp_valid_d;
  logic                   rsp_status_q, rsp_status_d;
  logic [SlotW-1:0]       rsp_slot_q, rsp_slot_d;
  logic [CntW-1:0]        rsp_cnt_q, rsp_cnt_d;

  logic           req_fire;
  logic           rsp_free;
  logic           start_scan;
  logic           imm_fail;
  logic [IW-1:0]  start_idx;
  logic           pos_in_range;
  logic [IW+PosW-1:0] pos_wide;
  logic           slot_vld;
  logic           match;
  logic           scan_hit;
  logic           scan_miss;
  logic [IdW-1:0] rd_data;
  logic           wr_en;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  // Start slot for find next; only used when it lies inside the table.
  assign pos_wide     = (IW + PosW)'(req_i.position);
  assign start_idx    = pos_wide[IW-1:0];
  assign pos_in_range = 32'(req_i.position) < TABLE_DEPTH;

  // Decode of a fresh request: scan, or answer at once.
  always_comb begin
    start_scan = 1'b0;
    imm_fail   = 1'b1;
    unique case (req_i.req_type) inside
      OP_ADD:                start_scan = (count_q < FullCnt);
      OP_DEL_ID, OP_FIND_ID: start_scan = 1'b1;
      OP_DEL_ORD:            start_scan = (MW'(req_i.position) < MW'(count_q));
      OP_FIND_NEXT:          start_scan = pos_in_range;
      OP_CLEAR:              imm_fail   = 1'b0;
      default:               start_scan = 1'b0;
    endcase
  end

  cist_id_ram #(
    .Depth (TABLE_DEPTH),
    .AddrW (IW)
  ) u_id_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (chk_idx_q),
    .wr_data_i (id_q),
    .rd_addr_i (scan_idx_q),
    .rd_data_o (rd_data)
  );

  // Shared slot test: one slot per cycle, one behind the read address.
  assign slot_vld = valid_q[chk_idx_q];

  always_comb begin
    unique case (op_q) inside
      OP_ADD:                match = !slot_vld;
      OP_DEL_ID, OP_FIND_ID: match = slot_vld && (rd_data == id_q);
      OP_DEL_ORD:            match = slot_vld && (MW'(seen_q) == MW'(pos_q));
      OP_FIND_NEXT:          match = slot_vld;
      default:               match = 1'b0;
    endcase
  end

  assign scan_hit  = (state_q == ST_SCAN) && chk_vld_q && match;
  assign scan_miss = (state_q == ST_SCAN) && chk_vld_q && !match && (chk_idx_q == LastIdx);
  assign wr_en     = scan_hit && (op_q == OP_ADD);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = start_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_miss) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_d         = op_q;
    id_d         = id_q;
    pos_d        = pos_q;
    scan_idx_d   = scan_idx_q;
    issue_end_d  = issue_end_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    seen_d       = seen_q;
    valid_d      = valid_q;
    count_d      = count_q;
    res_fail_d   = res_fail_q;
    res_slot_d   = res_slot_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_slot_d   = rsp_slot_q;
    rsp_cnt_d    = rsp_cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d        = req_i.req_type;
          id_d        = req_i.card_id;
          pos_d       = req_i.position;
          scan_idx_d  = (req_i.req_type == OP_FIND_NEXT) ? start_idx : '0;
          issue_end_d = 1'b0;
          seen_d      = '0;
          res_fail_d  = imm_fail;
          res_slot_d  = '0;
          if (req_i.req_type == OP_CLEAR) begin
            valid_d = '0;
            count_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (!issue_end_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = scan_idx_q;
          if (scan_idx_q == LastIdx) begin
            issue_end_d = 1'b1;
          end else begin
            scan_idx_d = scan_idx_q + 1'b1;
          end
        end
        if (chk_vld_q && slot_vld) begin
          seen_d = seen_q + 1'b1;
        end
        if (scan_hit) begin
          chk_vld_d  = 1'b0;
          res_fail_d = 1'b0;
          res_slot_d = chk_idx_q;
          if (op_q == OP_ADD) begin
            valid_d[chk_idx_q] = 1'b1;
            count_d            = count_q + 1'b1;
          end else if (op_q == OP_DEL_ID || op_q == OP_DEL_ORD) begin
            valid_d[chk_idx_q] = 1'b0;
            count_d            = count_q - 1'b1;
          end
        end else if (scan_miss) begin
          chk_vld_d  = 1'b0;
          res_fail_d = 1'b1;
          res_slot_d = '0;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_fail_q;
          rsp_slot_d   = res_fail_q ? '0 : SlotW'(res_slot_q);
          rsp_cnt_d    = CntW'(count_q);
        end
      end
      default: chk_vld_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_idx_q  <= '0;
      issue_end_q <= 1'b0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      seen_q      <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      issue_end_q <= issue_end_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      seen_q      <= seen_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    pos_q        <= pos_d;
    res_fail_q   <= res_fail_d;
    res_slot_q   <= res_slot_d;
    rsp_status_q <= rsp_status_d;
    rsp_slot_q   <= rsp_slot_d;
    rsp_cnt_q    <= rsp_cnt_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.slot        = rsp_slot_q;
  assign rsp_o.entry_count = rsp_cnt_q;

  `CIST_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FullCnt, "entry count above table depth")
  `CIST_ASSERT(a_count_popcnt, clk_i, rst_ni, $countones(valid_q) == count_q, "count differs from valid bits")
  `CIST_ASSERT(a_add_sets_valid, clk_i, rst_ni, wr_en |=> valid_q[$past(chk_idx_q)], "added slot not marked valid")
  `CIST_ASSERT(a_scan_only_in_scan, clk_i, rst_ni, chk_vld_q |-> state_q == ST_SCAN, "slot test outside scan")
  `CIST_ASSERT_ALWAYS(a_fail_slot_zero, clk_i, (rsp_valid_q && rsp_status_q) |-> rsp_slot_q == '0, "failed request carries a slot")

endmodule
